### rtl/core/aabb_collision_query_table_assert.svh
// Assertion macros used by the collision table top level.
`ifndef AABB_COLLISION_QUERY_TABLE_ASSERT_SVH
`define AABB_COLLISION_QUERY_TABLE_ASSERT_SVH
`ifndef SYNTH
`define ACQT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");
`define ACQT_NEVER(lbl, expr) `ACQT_ASSERT(lbl, !(expr))
`else
`define ACQT_ASSERT(lbl, prop)
`define ACQT_NEVER(lbl, expr)
`endif
`endif

### rtl/core/acqt_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// acqt_pkg
// Types and constants shared by the box table chain and its top level.
// ---------------------------------------------------------------------------
package acqt_pkg;

  localparam int unsigned MAX_ENTRIES_DEF = 64;
  localparam int unsigned SLOT_W = 6;
  localparam int unsigned PEN_W  = 16;
  localparam int unsigned ARITH_W = 20;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_UPDATE = 2'd1,
    OP_QUERY  = 2'd2,
    OP_NOP    = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    SIDE_NONE   = 3'd0,
    SIDE_BOTTOM = 3'd1,
    SIDE_TOP    = 3'd2,
    SIDE_LEFT   = 3'd3,
    SIDE_RIGHT  = 3'd4
  } side_e;

  typedef struct packed {
    logic [15:0] cx;
    logic [15:0] cy;
    logic [13:0] hw;
    logic [13:0] hh;
  } box_t;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] other_slot;
    side_e             side;
    logic [PEN_W-1:0]  pen;
    logic              resolve;
    logic              bounce;
    logic              full;
  } result_t;

  typedef struct packed {
    logic              active;
    logic              q_sim;
    logic [SLOT_W-1:0] slot;
    box_t              box;
    result_t           res;
  } token_t;

  typedef struct packed {
    logic valid;
    box_t box;
    logic removed;
    logic sim;
    logic fixed;
  } wr_t;

endpackage

### rtl/core/aabb_collision_query_table.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// aabb_collision_query_table
// Box table with append, update and first-hit overlap query.
// ---------------------------------------------------------------------------
// Requests arrive on the s_axis channel, the opcode in tuser. Every request
// gives exactly one response on m_axis.
// Append, update and no-operation requests answer in the cycle after they are
// taken; the next request can be taken at the same edge that releases it.
// A query is a token that walks a row of MaxEntries cells, one slot per
// cycle, in slot order; the first overlapping entry fills in the result and
// later cells let it pass. The query is held in a launch register, then in
// each cell's register in turn, and its result is registered at the output;
// the row carries one query at a time, and no request is taken meanwhile.
// Reset clears the entry count and every slot's flags; no clearing pass is
// needed. When m_axis is stalled the response waits in its output register
// and no new request is taken until it can be released.
// ---------------------------------------------------------------------------
`include "aabb_collision_query_table_assert.svh"

module aabb_collision_query_table #(
  parameter int unsigned MaxEntries = acqt_pkg::MAX_ENTRIES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // slot[5:0], center_x[21:6], center_y[37:22], half_width[51:38],
  // half_height[65:52], removed[66], simulated[67], is_fixed[68],
  // fixed_check[69], zero[71:70]
  input  logic [71:0] s_axis_tdata,
  // opcode[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // hit[0], other_slot[6:1], touch_side[9:7], penetration[25:10],
  // resolve_needed[26], bounce[27], table_full[28], zero[31:29]
  output logic [31:0] m_axis_tdata
);
  localparam int unsigned IdxW = $clog2(MaxEntries);
  localparam int unsigned CntW = $clog2(MaxEntries + 1);
  localparam int unsigned CmpW = (CntW > acqt_pkg::SLOT_W) ? CntW : acqt_pkg::SLOT_W;

  acqt_pkg::op_e     op;
  logic [5:0]        slot;
  acqt_pkg::box_t    in_box;
  logic              in_removed, in_sim, in_fixed, in_check;
  logic              accept, full, upd_ok;
  acqt_pkg::wr_t     wr;
  logic [IdxW-1:0]   wr_idx;
  logic [CntW-1:0]   count_q;
  logic              busy_q;
  logic              out_valid_q;
  acqt_pkg::result_t out_res_q, imm_res;
  logic              launch_valid_q;
  acqt_pkg::token_t  launch_q;
  logic              chain_done;

  logic             tv [MaxEntries+1];
  acqt_pkg::token_t tk [MaxEntries+1];
  logic [MaxEntries:0] tv_vec;

  assign op         = acqt_pkg::op_e'(s_axis_tuser);
  assign slot       = s_axis_tdata[5:0];
  assign in_box.cx  = s_axis_tdata[21:6];
  assign in_box.cy  = s_axis_tdata[37:22];
  assign in_box.hw  = s_axis_tdata[51:38];
  assign in_box.hh  = s_axis_tdata[65:52];
  assign in_removed = s_axis_tdata[66];
  assign in_sim     = s_axis_tdata[67];
  assign in_fixed   = s_axis_tdata[68];
  assign in_check   = s_axis_tdata[69];

  assign s_axis_tready = !busy_q && (!out_valid_q || m_axis_tready);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign full          = (count_q == CntW'(MaxEntries));
  assign upd_ok        = (CmpW'(slot) < CmpW'(count_q)) && (CmpW'(slot) < CmpW'(MaxEntries));

  always_comb begin
    wr.box     = in_box;
    wr.removed = in_removed;
    wr.sim     = in_sim;
    wr.fixed   = in_fixed;
    wr.valid   = 1'b0;
    wr_idx     = IdxW'(slot);
    imm_res    = '0;
    unique case (op)
      acqt_pkg::OP_APPEND: begin
        wr.valid = accept && !full;
        wr_idx   = count_q[IdxW-1:0];
        if (full) begin
          imm_res.full = 1'b1;
        end else begin
          imm_res.other_slot = acqt_pkg::SLOT_W'(count_q);
        end
      end
      acqt_pkg::OP_UPDATE: wr.valid = accept && upd_ok;
      acqt_pkg::OP_QUERY:  wr.valid = 1'b0;
      acqt_pkg::OP_NOP:    wr.valid = 1'b0;
      default:             wr.valid = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (wr.valid && op == acqt_pkg::OP_APPEND) begin
      count_q <= count_q + CntW'(1);
    end
  end

  // The query token starts empty; a rejected query box never becomes active.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      launch_valid_q <= 1'b0;
    end else begin
      launch_valid_q <= accept && op == acqt_pkg::OP_QUERY;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      launch_q.active <= !in_removed && !(in_fixed && !in_check);
      launch_q.q_sim  <= in_sim;
      launch_q.slot   <= slot;
      launch_q.box    <= in_box;
      launch_q.res    <= '0;
    end
  end

  assign tv[0] = launch_valid_q;
  assign tk[0] = launch_q;

  for (genvar g = 0; g < MaxEntries; g++) begin : g_cell
    acqt_cell #(
      .MaxEntries(MaxEntries),
      .Idx       (g)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .wr_i       (wr),
      .wr_idx_i   (wr_idx),
      .tok_valid_i(tv[g]),
      .tok_i      (tk[g]),
      .tok_valid_o(tv[g+1]),
      .tok_o      (tk[g+1])
    );
  end

  for (genvar g = 0; g <= MaxEntries; g++) begin : g_tv
    assign tv_vec[g] = tv[g];
  end

  assign chain_done = tv[MaxEntries];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept && op == acqt_pkg::OP_QUERY) begin
        busy_q <= 1'b1;
      end else if (chain_done) begin
        busy_q <= 1'b0;
      end
      if ((accept && op != acqt_pkg::OP_QUERY) || chain_done) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && op != acqt_pkg::OP_QUERY) begin
      out_res_q <= imm_res;
    end else if (chain_done) begin
      out_res_q <= tk[MaxEntries].res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_res_q.full, out_res_q.bounce, out_res_q.resolve,
                          out_res_q.pen, out_res_q.side, out_res_q.other_slot,
                          out_res_q.hit};

  `ACQT_ASSERT(a_count_le_max, count_q <= CntW'(MaxEntries))
  `ACQT_ASSERT(a_one_token, $onehot0(tv_vec))
  `ACQT_ASSERT(a_done_when_busy, chain_done |-> busy_q && !out_valid_q)
  `ACQT_NEVER(a_no_accept_busy, busy_q && s_axis_tready)

endmodule

### rtl/core/acqt_cell.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// acqt_cell
// One table slot: holds a box and its flags, tests the passing query token.
// ---------------------------------------------------------------------------
module acqt_cell #(
  parameter int unsigned MaxEntries = acqt_pkg::MAX_ENTRIES_DEF,
  parameter int unsigned Idx        = 0
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  acqt_pkg::wr_t                 wr_i,
  input  logic [$clog2(MaxEntries)-1:0] wr_idx_i,
  input  logic                          tok_valid_i,
  input  acqt_pkg::token_t              tok_i,
  output logic                          tok_valid_o,
  output acqt_pkg::token_t              tok_o
);
  localparam int unsigned IdxW = $clog2(MaxEntries);
  localparam int unsigned AW   = acqt_pkg::ARITH_W;

  acqt_pkg::box_t   geo_q;
  logic             present_q, removed_q, sim_q, fixed_q;
  logic             valid_q;
  acqt_pkg::token_t tok_q, tok_d;

  logic signed [AW-1:0] qcx, qcy, qhw, qhh, ecx, ecy, ehw, ehh;
  logic signed [AW-1:0] ql, qr, qt, qb, el, er, et, eb, px, py, pen;
  logic                 x_lt, y_lt, overlap, skip, hit, use_x, both_sim;
  logic                 wr_hit;

  assign wr_hit = wr_i.valid && (wr_idx_i == IdxW'(Idx));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q <= 1'b0;
      removed_q <= 1'b0;
      sim_q     <= 1'b0;
      fixed_q   <= 1'b0;
    end else if (wr_hit) begin
      present_q <= 1'b1;
      removed_q <= wr_i.removed;
      sim_q     <= wr_i.sim;
      fixed_q   <= wr_i.fixed;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_hit) begin
      geo_q <= wr_i.box;
    end
  end

  always_comb begin
    qcx = AW'($signed(tok_i.box.cx));
    qcy = AW'($signed(tok_i.box.cy));
    qhw = $signed(AW'(tok_i.box.hw));
    qhh = $signed(AW'(tok_i.box.hh));
    ecx = AW'($signed(geo_q.cx));
    ecy = AW'($signed(geo_q.cy));
    ehw = $signed(AW'(geo_q.hw));
    ehh = $signed(AW'(geo_q.hh));
    ql = qcx - qhw;
    qr = qcx + qhw;
    qt = qcy - qhh;
    qb = qcy + qhh;
    el = ecx - ehw;
    er = ecx + ehw;
    et = ecy - ehh;
    eb = ecy + ehh;
    overlap = !(ql > er || qr < el || qt > eb || qb < et);
    x_lt = qcx < ecx;
    y_lt = qcy < ecy;
    px = x_lt ? (qr - el) : (er - ql);
    py = y_lt ? (qb - et) : (eb - qt);
    use_x = px < py;
    pen = use_x ? px : py;
    skip = (Idx < 64) && (AW'(tok_i.slot) == AW'(Idx));
    hit = tok_i.active && !tok_i.res.hit && present_q && !removed_q && !skip && overlap;
    both_sim = tok_i.q_sim && sim_q;

    tok_d = tok_i;
    if (hit) begin
      tok_d.res.hit        = 1'b1;
      tok_d.res.other_slot = acqt_pkg::SLOT_W'(Idx);
      if (use_x) begin
        tok_d.res.side = x_lt ? acqt_pkg::SIDE_LEFT : acqt_pkg::SIDE_RIGHT;
      end else begin
        tok_d.res.side = y_lt ? acqt_pkg::SIDE_BOTTOM : acqt_pkg::SIDE_TOP;
      end
      if (pen < 0) begin
        tok_d.res.pen = '0;
      end else if (pen > $signed(AW'(65535))) begin
        tok_d.res.pen = '1;
      end else begin
        tok_d.res.pen = pen[acqt_pkg::PEN_W-1:0];
      end
      tok_d.res.resolve = both_sim;
      tok_d.res.bounce  = both_sim && !use_x && y_lt && !fixed_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= tok_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_q <= tok_d;
  end

  assign tok_valid_o = valid_q;
  assign tok_o       = tok_q;

endmodule

### dv/tb_aabb_collision_query_table.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_aabb_collision_query_table
// Self-checking bench for the box table: a predictor of append, update and
// first-hit query runs beside the block and every response is compared.
// ---------------------------------------------------------------------------
module tb_aabb_collision_query_table;

  localparam int unsigned NUM_SLOTS = 64;
  localparam int unsigned WATCHDOG_LIMIT = 20000;

  typedef struct {
    acqt_pkg::op_e op;
    logic [5:0]  slot;
    logic [15:0] cx;
    logic [15:0] cy;
    logic [13:0] hw;
    logic [13:0] hh;
    logic        removed;
    logic        sim;
    logic        fixed;
    logic        fixed_check;
  } request_t;

  typedef struct {
    logic        hit;
    logic [5:0]  other_slot;
    logic [2:0]  side;
    logic [15:0] pen;
    logic        resolve;
    logic        bounce;
    logic        full;
  } response_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;

  aabb_collision_query_table uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Mirror of the table contents.
  int          tbl_cx[NUM_SLOTS];
  int          tbl_cy[NUM_SLOTS];
  int          tbl_hw[NUM_SLOTS];
  int          tbl_hh[NUM_SLOTS];
  logic        tbl_removed[NUM_SLOTS];
  logic        tbl_sim[NUM_SLOTS];
  logic        tbl_fixed[NUM_SLOTS];
  int          tbl_count;

  request_t    pending_requests[$];
  response_t   expected_responses[$];
  int          error_count = 0;
  bit          hold_off_req;
  bit          drain_req;
  int          idle_cycles = 0;
  int          in_count = 0;
  int          out_count = 0;

  function automatic response_t predict_response(request_t r);
    response_t res;
    int qx, qy, qw, qh, ex, ey, ew, eh, px, py, pen;
    logic [2:0] side;
    res = '{default: '0};
    qx = $signed(r.cx);
    qy = $signed(r.cy);
    qw = r.hw;
    qh = r.hh;
    case (r.op)
      acqt_pkg::OP_APPEND: begin
        if (tbl_count < NUM_SLOTS) begin
          tbl_cx[tbl_count] = qx; tbl_cy[tbl_count] = qy;
          tbl_hw[tbl_count] = qw; tbl_hh[tbl_count] = qh;
          tbl_removed[tbl_count] = r.removed;
          tbl_sim[tbl_count] = r.sim;
          tbl_fixed[tbl_count] = r.fixed;
          res.other_slot = tbl_count[5:0];
          tbl_count++;
        end else begin
          res.full = 1'b1;
        end
      end
      acqt_pkg::OP_UPDATE: begin
        if (r.slot < tbl_count) begin
          tbl_cx[r.slot] = qx; tbl_cy[r.slot] = qy;
          tbl_hw[r.slot] = qw; tbl_hh[r.slot] = qh;
          tbl_removed[r.slot] = r.removed;
          tbl_sim[r.slot] = r.sim;
          tbl_fixed[r.slot] = r.fixed;
        end
      end
      acqt_pkg::OP_QUERY: begin
        if (!(r.removed || (r.fixed && !r.fixed_check))) begin
          for (int i = 0; i < tbl_count; i++) begin
            if (i == r.slot || tbl_removed[i]) continue;
            ex = tbl_cx[i]; ey = tbl_cy[i]; ew = tbl_hw[i]; eh = tbl_hh[i];
            if (qx - qw > ex + ew || qx + qw < ex - ew ||
                qy - qh > ey + eh || qy + qh < ey - eh) continue;
            px = (qx < ex) ? (qx + qw) - (ex - ew) : (ex + ew) - (qx - qw);
            py = (qy < ey) ? (qy + qh) - (ey - eh) : (ey + eh) - (qy - qh);
            if (px < py) begin
              pen = px;
              side = (qx < ex) ? acqt_pkg::SIDE_LEFT : acqt_pkg::SIDE_RIGHT;
            end else begin
              pen = py;
              side = (qy < ey) ? acqt_pkg::SIDE_BOTTOM : acqt_pkg::SIDE_TOP;
            end
            if (pen < 0) pen = 0;
            if (pen > 65535) pen = 65535;
            res.hit = 1'b1;
            res.other_slot = i[5:0];
            res.side = side;
            res.pen = pen[15:0];
            res.resolve = r.sim && tbl_sim[i];
            res.bounce = res.resolve && side == acqt_pkg::SIDE_BOTTOM && !tbl_fixed[i];
            break;
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic request_t make_box(acqt_pkg::op_e op, int cx, int cy, int hw, int hh);
    request_t r;
    r.op = op;
    r.slot = 6'($urandom_range(0, 63));
    r.cx = 16'(cx);
    r.cy = 16'(cy);
    r.hw = 14'(hw);
    r.hh = 14'(hh);
    r.removed = 1'b0;
    r.sim = 1'($urandom);
    r.fixed = 1'b0;
    r.fixed_check = 1'($urandom);
    return r;
  endfunction

  // Random request: mostly boxes clustered near the origin so that
  // queries hit, a few with fields spread over their whole range.
  function automatic request_t random_request();
    request_t r;
    int pick;
    pick = $urandom_range(0, 99);
    r = make_box(acqt_pkg::OP_QUERY, $urandom_range(0, 800) - 400,
                 $urandom_range(0, 800) - 400,
                 $urandom_range(0, 200), $urandom_range(0, 200));
    if (pick < 20) r.op = acqt_pkg::OP_APPEND;
    else if (pick < 40) r.op = acqt_pkg::OP_UPDATE;
    else if (pick < 95) r.op = acqt_pkg::OP_QUERY;
    else r.op = acqt_pkg::OP_NOP;
    if ($urandom_range(0, 9) == 0) begin
      r.cx = 16'($urandom);
      r.cy = 16'($urandom);
      r.hw = 14'($urandom);
      r.hh = 14'($urandom);
    end
    r.removed = ($urandom_range(0, 7) == 0);
    r.fixed = ($urandom_range(0, 3) == 0);
    if (r.op == acqt_pkg::OP_UPDATE && tbl_count > 0 && $urandom_range(0, 3) != 0)
      r.slot = 6'($urandom_range(0, tbl_count - 1));
    return r;
  endfunction

  // Driver. A request stays on the bus unchanged until it is taken.
  int      gap_left = 0;
  int      in_seen = 0;
  bit      in_taken;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      in_taken = 1'b0;
      if (in_count != in_seen) begin
        in_seen = in_count;
        in_taken = 1'b1;
        expected_responses.push_back(predict_response(pending_requests.pop_front()));
        gap_left = $urandom_range(0, 1) ? 0 : $urandom_range(0, 12);
      end
      if (s_axis_tvalid && !in_taken) begin
        s_axis_tvalid <= 1'b1;
      end else if (drain_req && expected_responses.size() != 0) begin
        s_axis_tvalid <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_requests.size() != 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= pending_requests[0].op;
        s_axis_tdata <= {2'b0, pending_requests[0].fixed_check, pending_requests[0].fixed,
                         pending_requests[0].sim, pending_requests[0].removed,
                         pending_requests[0].hh, pending_requests[0].hw,
                         pending_requests[0].cy, pending_requests[0].cx,
                         pending_requests[0].slot};
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver back-pressure: a wait drawn for every response, and one long stall.
  int      hold_left = 0;
  bit      hold_taken = 1'b0;
  int      ready_wait = 0;
  int      out_seen = 0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_count != out_seen) begin
        out_seen = out_count;
        ready_wait = $urandom_range(0, 12);
      end
      if (hold_off_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (m_axis_tvalid && ready_wait > 0) begin
        ready_wait--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Monitor and watchdog.
  response_t got;
  response_t want;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) in_count++;
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        out_count++;
        got.hit = m_axis_tdata[0];
        got.other_slot = m_axis_tdata[6:1];
        got.side = m_axis_tdata[9:7];
        got.pen = m_axis_tdata[25:10];
        got.resolve = m_axis_tdata[26];
        got.bounce = m_axis_tdata[27];
        got.full = m_axis_tdata[28];
        if (expected_responses.size() == 0) begin
          $error("response with none expected: %h", m_axis_tdata);
          error_count++;
        end else begin
          want = expected_responses.pop_front();
          if (got.hit !== want.hit) begin
            $error("hit: expected %0d got %0d", want.hit, got.hit); error_count++;
          end
          if (got.other_slot !== want.other_slot) begin
            $error("other_slot: expected %0d got %0d", want.other_slot, got.other_slot);
            error_count++;
          end
          if (got.side !== want.side) begin
            $error("touch_side: expected %0d got %0d", want.side, got.side); error_count++;
          end
          if (got.pen !== want.pen) begin
            $error("penetration: expected %0d got %0d", want.pen, got.pen); error_count++;
          end
          if (got.resolve !== want.resolve) begin
            $error("resolve_needed: expected %0d got %0d", want.resolve, got.resolve);
            error_count++;
          end
          if (got.bounce !== want.bounce) begin
            $error("bounce: expected %0d got %0d", want.bounce, got.bounce); error_count++;
          end
          if (got.full !== want.full) begin
            $error("table_full: expected %0d got %0d", want.full, got.full); error_count++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_aabb_collision_query_table NOT OK");
      $finish;
    end
  end

  // Directed requests aim at the corner cases: touching edges, the y tie,
  // deep overlap, rejected query boxes and the own-slot skip.
  task automatic load_directed();
    request_t r;
    pending_requests.push_back(make_box(acqt_pkg::OP_QUERY, 0, 0, 10, 10));
    pending_requests.push_back(make_box(acqt_pkg::OP_APPEND, 0, 0, 16, 16));
    pending_requests.push_back(make_box(acqt_pkg::OP_APPEND, -32768, 32767, 16383, 16383));
    r = make_box(acqt_pkg::OP_APPEND, 32767, -32768, 16383, 0); r.sim = 1; r.fixed = 1;
    pending_requests.push_back(r);
    r = make_box(acqt_pkg::OP_QUERY, 32, 0, 16, 16); r.slot = 63;
    pending_requests.push_back(r);
    r = make_box(acqt_pkg::OP_QUERY, 10, 10, 16, 16); r.slot = 63;
    pending_requests.push_back(r);
    r = make_box(acqt_pkg::OP_QUERY, 0, -20, 16, 16); r.sim = 1; r.slot = 63;
    pending_requests.push_back(r);
    r = make_box(acqt_pkg::OP_QUERY, 0, 0, 16, 16); r.slot = 0;
    pending_requests.push_back(r);
    r = make_box(acqt_pkg::OP_QUERY, 0, 0, 16, 16); r.removed = 1;
    pending_requests.push_back(r);
    r = make_box(acqt_pkg::OP_QUERY, 0, 0, 16, 16); r.fixed = 1; r.fixed_check = 0;
    pending_requests.push_back(r);
    r = make_box(acqt_pkg::OP_QUERY, 0, 0, 16, 16); r.fixed = 1; r.fixed_check = 1;
    r.slot = 5;
    pending_requests.push_back(r);
    r = make_box(acqt_pkg::OP_QUERY, -32768, 32767, 16383, 16383); r.slot = 1;
    pending_requests.push_back(r);
    r = make_box(acqt_pkg::OP_UPDATE, 5, 5, 1, 1); r.slot = 0; r.removed = 1;
    pending_requests.push_back(r);
    r = make_box(acqt_pkg::OP_UPDATE, 5, 5, 1, 1); r.slot = 63;
    pending_requests.push_back(r);
    r = make_box(acqt_pkg::OP_NOP, -1, -1, 16383, 16383); r.slot = 63; r.removed = 1;
    pending_requests.push_back(r);
    r = make_box(acqt_pkg::OP_QUERY, 0, 0, 16, 16); r.slot = 63;
    pending_requests.push_back(r);
  endtask

  initial begin
    request_t r;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = acqt_pkg::OP_NOP;
    m_axis_tready = 1'b0;
    hold_off_req = 1'b0;
    drain_req = 1'b0;
    tbl_count = 0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      tbl_removed[i] = 1'b0; tbl_sim[i] = 1'b0; tbl_fixed[i] = 1'b0;
    end
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    load_directed();
    wait (pending_requests.size() == 0);
    // Sender pause until everything has been answered.
    drain_req = 1'b1;
    wait (expected_responses.size() == 0);
    drain_req = 1'b0;

    // Long receiver stall while a burst of appends and queries keeps coming.
    hold_off_req = 1'b1;
    for (int n = 0; n < 20; n++) pending_requests.push_back(random_request());
    for (int n = 0; n < 880; n++) begin
      // Fill up to and past a full table about midway.
      if (n >= 400 && n < 470) begin
        r = random_request(); r.op = acqt_pkg::OP_APPEND;
        pending_requests.push_back(r);
      end else begin
        pending_requests.push_back(random_request());
      end
    end
    wait (pending_requests.size() == 0);
    wait (expected_responses.size() == 0);
    repeat (200) @(posedge clk_i);
    if (error_count == 0) begin
      $display("tb_aabb_collision_query_table OK");
    end else begin
      $display("tb_aabb_collision_query_table NOT OK");
    end
    $finish;
  end

endmodule
